// File: sv/block_reference_consistency_checker_core_macros.svh
// Assertion macros shared by the checker's controller and datapath.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef BLOCK_REFERENCE_CONSISTENCY_CHECKER_CORE_MACROS_SVH
`define BLOCK_REFERENCE_CONSISTENCY_CHECKER_CORE_MACROS_SVH

// Same-cycle implication.
`define BRCC_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication.
`define BRCC_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: sv/brcc_pkg.sv
// Package of the bitmap consistency checker: sizes, item kinds and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package brcc_pkg;

   // Store sizes.
   localparam int MAX_BLOCKS         = 64;
   localparam int POINTERS_PER_INODE = 15;
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SEEN_W = $clog2(POINTERS_PER_INODE + 1);

   // Field widths.
   localparam int KIND_W      = 3;
   localparam int BIDX_W      = 6;
   localparam int WORD_W      = 32;
   localparam int CFG_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int SUM_W       = 7;
   localparam int IMIS_W      = 8;
   localparam int BAD_W       = 12;
   localparam int VINODE_W    = 8;

   // Register reset values.
   localparam logic [CFG_W-1:0] FIRST_DATA_RESET   = 7'd8;
   localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RESET = 7'd64;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_DATA   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_BLOCKS = 1'd1;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BITMAP = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HEADER = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PTR    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FINISH = 3'd4;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic rmw_wr;
      logic walk_step;
      logic walk_done;
   } brcc_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic slot_free;
      logic ptr_rmw;
      logic walk_empty;
      logic walk_last;
   } brcc_status_type;

   // Number of data blocks covered by the configured range.
   function automatic logic [CNT_W-1:0] data_count(input logic [CFG_W-1:0] first,
                                                   input logic [CFG_W-1:0] total);
      logic [CFG_W-1:0] diff;
      diff = total - first;
      if (first >= total) begin
         return '0;
      end else if (32'(diff) > MAX_BLOCKS) begin
         return CNT_W'(MAX_BLOCKS);
      end else begin
         return CNT_W'(diff);
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/brcc_if.sv
// Channel interfaces of the bitmap consistency checker: items, results and
// register writes. Depends on brcc_pkg.
`default_nettype none

interface brcc_req_if import brcc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BIDX_W-1:0]   block_index;
   logic                bitmap_bit;
   logic [WORD_W-1:0]   link_count;
   logic [WORD_W-1:0]   delete_time;
   logic [WORD_W-1:0]   block_pointer;

   modport source (output valid, kind, block_index, bitmap_bit, link_count,
                   delete_time, block_pointer, input ready);
   modport sink   (input valid, kind, block_index, bitmap_bit, link_count,
                   delete_time, block_pointer, output ready);
endinterface

interface brcc_rsp_if import brcc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                inode_valid;
   logic                inode_mismatch;
   logic                bad_pointer;
   logic                done_res;
   logic [SUM_W-1:0]    data_mismatch_count;
   logic [SUM_W-1:0]    dup_block_count;
   logic [SUM_W-1:0]    referenced_count;
   logic [SUM_W-1:0]    bitmap_used_count;
   logic [IMIS_W-1:0]   inode_mismatch_total;
   logic [BAD_W-1:0]    bad_pointer_total;
   logic [VINODE_W-1:0] valid_inode_total;

   modport source (output valid, inode_valid, inode_mismatch, bad_pointer, done_res,
                   data_mismatch_count, dup_block_count, referenced_count,
                   bitmap_used_count, inode_mismatch_total, bad_pointer_total,
                   valid_inode_total, input ready);
   modport sink   (input valid, inode_valid, inode_mismatch, bad_pointer, done_res,
                   data_mismatch_count, dup_block_count, referenced_count,
                   bitmap_used_count, inode_mismatch_total, bad_pointer_total,
                   valid_inode_total, output ready);
endinterface

interface brcc_csr_if import brcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/brcc_ctrl.sv
// Controller of the bitmap consistency checker: sequences accept, pointer
// read-modify-write and the finish walk. Depends on brcc_pkg and brcc_if.
`default_nettype none

`include "block_reference_consistency_checker_core_macros.svh"

module brcc_ctrl import brcc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   brcc_req_if.sink             req_chan,
   input  wire brcc_status_type status,
   output brcc_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_PTR_WR   = 2'd1;
   localparam logic [1:0] ST_WALK     = 2'd2;
   localparam logic [1:0] ST_WALK_END = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       ready;

   // An item is taken only in idle and when the result register can take its result.
   assign ready           = (state_ff == ST_IDLE) && status.slot_free;
   assign req_chan.ready  = ready;
   assign cmd.accept      = ready && req_chan.valid;
   assign cmd.rmw_wr      = (state_ff == ST_PTR_WR);
   assign cmd.walk_step   = (state_ff == ST_WALK);
   assign cmd.walk_done   = (state_ff == ST_WALK_END);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               if ((req_chan.kind == KIND_PTR) && status.ptr_rmw) begin
                  state_in = ST_PTR_WR;
               end else if ((req_chan.kind == KIND_FINISH) && !status.walk_empty) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_PTR_WR: begin
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (status.walk_last) begin
               state_in = ST_WALK_END;
            end
         end
         ST_WALK_END: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The write half of a pointer update lasts exactly one cycle.
   `BRCC_CHECK_NEXT(a_ptr_wr_one_cycle, state_ff == ST_PTR_WR, state_ff == ST_IDLE)
   // The walk's result cycle always follows the walk itself.
   `BRCC_CHECK(a_walk_end_after_walk, state_ff == ST_WALK_END, $past(state_ff) == ST_WALK)

endmodule

`default_nettype wire

// File: sv/brcc_datapath.sv
// Datapath of the bitmap consistency checker: registers, bitmap and reference
// count stores, counters and the result register. Depends on brcc_pkg and brcc_if.
`default_nettype none

`include "block_reference_consistency_checker_core_macros.svh"

module brcc_datapath import brcc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   brcc_req_if.sink           req_chan,
   brcc_csr_if.sink           csr_chan,
   brcc_rsp_if.source         rsp_chan,
   input  wire brcc_cmd_type  cmd,
   output brcc_status_type    status
);

   // Configuration registers.
   logic [CFG_W-1:0] first_ff;
   logic [CFG_W-1:0] total_ff;
   logic [CNT_W-1:0] count;

   // Inode tracking and running totals.
   logic                cur_valid_ff, cur_valid_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [IMIS_W-1:0]   imis_tot_ff, imis_tot_in;
   logic [BAD_W-1:0]    bad_tot_ff, bad_tot_in;
   logic [VINODE_W-1:0] vinode_tot_ff, vinode_tot_in;

   // Stores and their written flags.
   logic                  used_mem [MAX_BLOCKS];
   logic [1:0]            ref_mem  [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] used_vld_ff;
   logic [MAX_BLOCKS-1:0] ref_vld_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  used_rd_ff, used_hit_ff;
   logic [1:0]            ref_rd_ff;
   logic                  ref_hit_ff;
   logic [IDX_W-1:0]      rmw_addr_ff;
   logic [1:0]            ref_old, ref_new;

   // Walk state.
   logic [IDX_W-1:0] walk_ff;
   logic             acc_en_ff;
   logic [CNT_W-1:0] c_mis_ff, c_mis_in;
   logic [CNT_W-1:0] c_dup_ff, c_dup_in;
   logic [CNT_W-1:0] c_ref_ff, c_ref_in;
   logic [CNT_W-1:0] c_used_ff, c_used_in;
   logic             used_e;
   logic             refd_e;
   logic             dup_e;

   // Item decode.
   logic              is_clear, is_bitmap, is_header, is_ptr, is_finish;
   logic              hdr_valid, hdr_mis;
   logic              idx_ok;
   logic              ptr_take, ptr_out, ptr_bad, ptr_rmw;
   logic [WORD_W-1:0] lo_bound, hi_bound;
   logic [WORD_W-1:0] ptr_off;
   logic [IDX_W-1:0]  ptr_addr;
   logic              load_imm, load;
   logic              rsp_valid_ff;

   assign count = data_count(first_ff, total_ff);

   // Register writes; the port never stalls.
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= FIRST_DATA_RESET;
         total_ff <= TOTAL_BLOCKS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_FIRST_DATA:   first_ff <= csr_chan.data;
            REG_TOTAL_BLOCKS: total_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Decode of the item at the input.
   assign is_clear  = cmd.accept && (req_chan.kind == KIND_CLEAR);
   assign is_bitmap = cmd.accept && (req_chan.kind == KIND_BITMAP);
   assign is_header = cmd.accept && (req_chan.kind == KIND_HEADER);
   assign is_ptr    = cmd.accept && (req_chan.kind == KIND_PTR);
   assign is_finish = cmd.accept && (req_chan.kind == KIND_FINISH);

   assign hdr_valid = (req_chan.link_count != '0) && (req_chan.delete_time == '0);
   assign hdr_mis   = req_chan.bitmap_bit != hdr_valid;
   assign idx_ok    = 32'(req_chan.block_index) < MAX_BLOCKS;

   // Pointer range check against the configured data range.
   assign lo_bound = WORD_W'(first_ff);
   assign hi_bound = WORD_W'(first_ff) + WORD_W'(count);
   assign ptr_take = cur_valid_ff && (seen_ff < SEEN_W'(POINTERS_PER_INODE));
   assign ptr_out  = (req_chan.block_pointer < lo_bound) ||
                     (req_chan.block_pointer >= hi_bound);
   assign ptr_bad  = ptr_take && (req_chan.block_pointer != '0) && ptr_out;
   assign ptr_rmw  = ptr_take && (req_chan.block_pointer != '0) && !ptr_out;
   assign ptr_off  = req_chan.block_pointer - lo_bound;
   assign ptr_addr = ptr_off[IDX_W-1:0];

   assign status.slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign status.ptr_rmw    = ptr_rmw;
   assign status.walk_empty = (count == '0);
   assign status.walk_last  = CNT_W'(walk_ff) == (count - CNT_W'(1));

   // Running totals and inode state, all saturating.
   always_comb begin
      cur_valid_in  = cur_valid_ff;
      seen_in       = seen_ff;
      imis_tot_in   = imis_tot_ff;
      bad_tot_in    = bad_tot_ff;
      vinode_tot_in = vinode_tot_ff;
      if (is_header) begin
         cur_valid_in = hdr_valid;
         seen_in      = '0;
         if (hdr_valid && (vinode_tot_ff != '1)) begin
            vinode_tot_in = vinode_tot_ff + VINODE_W'(1);
         end
         if (hdr_mis && (imis_tot_ff != '1)) begin
            imis_tot_in = imis_tot_ff + IMIS_W'(1);
         end
      end
      if (is_ptr && ptr_take) begin
         seen_in = seen_ff + SEEN_W'(1);
      end
      if (is_ptr && ptr_bad && (bad_tot_ff != '1)) begin
         bad_tot_in = bad_tot_ff + BAD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         seen_ff       <= '0;
         imis_tot_ff   <= '0;
         bad_tot_ff    <= '0;
         vinode_tot_ff <= '0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         seen_ff       <= seen_in;
         imis_tot_ff   <= imis_tot_in;
         bad_tot_ff    <= bad_tot_in;
         vinode_tot_ff <= vinode_tot_in;
      end
   end

   // Written flags: an entry that was not written since reset or a clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset || is_clear) begin
         used_vld_ff <= '0;
         ref_vld_ff  <= '0;
      end else begin
         if (is_bitmap && idx_ok) begin
            used_vld_ff[IDX_W'(req_chan.block_index)] <= 1'b1;
         end
         if (cmd.rmw_wr) begin
            ref_vld_ff[rmw_addr_ff] <= 1'b1;
         end
      end
   end

   // One read address serves both the pointer update and the walk.
   assign rd_addr = cmd.walk_step ? walk_ff : ptr_addr;

   // Bitmap store.
   always_ff @(posedge clock) begin
      if (is_bitmap && idx_ok) begin
         used_mem[IDX_W'(req_chan.block_index)] <= req_chan.bitmap_bit;
      end
      used_rd_ff <= used_mem[rd_addr];
   end

   // Reference count store, updated by read-modify-write.
   always_ff @(posedge clock) begin
      if (cmd.rmw_wr) begin
         ref_mem[rmw_addr_ff] <= ref_new;
      end
      ref_rd_ff <= ref_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      used_hit_ff <= used_vld_ff[rd_addr];
      ref_hit_ff  <= ref_vld_ff[rd_addr];
      if (cmd.accept) begin
         rmw_addr_ff <= ptr_addr;
      end
   end

   assign ref_old = ref_hit_ff ? ref_rd_ff : 2'd0;
   assign ref_new = (ref_old == 2'd3) ? 2'd3 : ref_old + 2'd1;

   // Finish walk: the read of one entry overlaps the count of the one before.
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff   <= '0;
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.walk_step;
         if (is_finish) begin
            walk_ff <= '0;
         end else if (cmd.walk_step) begin
            walk_ff <= walk_ff + IDX_W'(1);
         end
      end
   end

   assign used_e = used_hit_ff && used_rd_ff;
   assign refd_e = ref_old != 2'd0;
   assign dup_e  = ref_old > 2'd1;

   always_comb begin
      c_mis_in  = c_mis_ff;
      c_dup_in  = c_dup_ff;
      c_ref_in  = c_ref_ff;
      c_used_in = c_used_ff;
      if (is_finish) begin
         c_mis_in  = '0;
         c_dup_in  = '0;
         c_ref_in  = '0;
         c_used_in = '0;
      end else if (acc_en_ff) begin
         c_mis_in  = c_mis_ff + CNT_W'(used_e != refd_e);
         c_dup_in  = c_dup_ff + CNT_W'(dup_e);
         c_ref_in  = c_ref_ff + CNT_W'(refd_e);
         c_used_in = c_used_ff + CNT_W'(used_e);
      end
   end

   always_ff @(posedge clock) begin
      c_mis_ff  <= c_mis_in;
      c_dup_ff  <= c_dup_in;
      c_ref_ff  <= c_ref_in;
      c_used_ff <= c_used_in;
   end

   // Result register: items without further work load it when taken.
   assign load_imm = cmd.accept && !(is_ptr && ptr_rmw) && !(is_finish && (count != '0));
   assign load     = load_imm || cmd.rmw_wr || cmd.walk_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_chan.inode_valid          <= load_imm && is_header && hdr_valid;
         rsp_chan.inode_mismatch       <= load_imm && is_header && hdr_mis;
         rsp_chan.bad_pointer          <= load_imm && is_ptr && ptr_bad;
         rsp_chan.done_res             <= (load_imm && is_finish) || cmd.walk_done;
         rsp_chan.data_mismatch_count  <= cmd.walk_done ? SUM_W'(c_mis_in) : '0;
         rsp_chan.dup_block_count      <= cmd.walk_done ? SUM_W'(c_dup_in) : '0;
         rsp_chan.referenced_count     <= cmd.walk_done ? SUM_W'(c_ref_in) : '0;
         rsp_chan.bitmap_used_count    <= cmd.walk_done ? SUM_W'(c_used_in) : '0;
         rsp_chan.inode_mismatch_total <= imis_tot_in;
         rsp_chan.bad_pointer_total    <= bad_tot_in;
         rsp_chan.valid_inode_total    <= vinode_tot_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   // A result never overwrites one that has not been taken.
   `BRCC_CHECK(a_load_into_free_slot, load, !rsp_valid_ff || rsp_chan.ready)
   // A counting pointer is written back in the cycle right after its read.
   `BRCC_CHECK_NEXT(a_rmw_follows_read, is_ptr && ptr_rmw, cmd.rmw_wr)

endmodule

`default_nettype wire

// File: sv/block_reference_consistency_checker_core.sv
// Bitmap consistency checker, top level. Items enter on req_chan and one
// result per item leaves on rsp_chan; register writes come on csr_chan.
// Register 0 sets the first data block, register 1 the total block count;
// write them only while no item is in flight. Each channel transfers on a
// clock edge with valid and ready both high.
// Flow: for clear, bitmap, header, unknown and non-counting pointer items, and
// finish items with an empty range, the result sits in the output register in
// the cycle after the item is taken (one item per cycle while the receiver
// keeps up). A pointer that bumps a reference count reads and then writes the
// reference count store; no item is taken until the write. Any other finish
// item walks the range, one store entry read per cycle, then loads its result.
// Reset is synchronous and active high; it restores the registers, clears
// the running totals, and marks every bitmap and reference count entry
// unwritten, so they read as zero at once with no sweep. A clear item does
// the same to the stores. While the receiver stalls, the result is held and
// no further item is taken.
// Depends on brcc_pkg, brcc_if, brcc_ctrl and brcc_datapath.
`default_nettype none

module block_reference_consistency_checker_core import brcc_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   brcc_req_if.sink   req_chan,
   brcc_rsp_if.source rsp_chan,
   brcc_csr_if.sink   csr_chan
);

   brcc_cmd_type    cmd;
   brcc_status_type status;

   // Controller: state machine and handshake.
   brcc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .status   (status),
      .cmd      (cmd)
   );

   // Datapath: stores, counters and result register.
   brcc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

`default_nettype wire
